// File: rtl/pfla_pkg.sv
// Shared constants and codes for the page free list allocator.
`default_nettype none

package pfla_pkg;

  localparam int unsigned MAX_PAGES_DEF   = 4096;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned MODE_W    = 3;
  localparam int unsigned PAGE_W    = 12;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned REFCNT_W  = 16;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_INIT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INCREF = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DECREF = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BUSY      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_BEGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_END   = 2'd2;

  localparam logic [CFG_W-1:0] PAGE_COUNT_RST     = 13'd4096;
  localparam logic [CFG_W-1:0] RESERVED_BEGIN_RST = 13'd160;
  localparam logic [CFG_W-1:0] RESERVED_END_RST   = 13'd256;

endpackage

`default_nettype wire

// File: rtl/pfla_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
`default_nettype none

module pfla_ram #(
  parameter int unsigned WIDTH = pfla_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned DEPTH = pfla_pkg::MAX_PAGES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/page_free_list_allocator_core.sv
// Page allocator top level: LIFO free list and per-page reference counts.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | mode_i, page_i
//   out     | out       | out_valid_o/out_ready_i | status_o, page_out_o, ref_count_o,
//           |           |                         | was_freed_o
//
// Alloc, free, incref, decref: the link and count memories are read when the item is taken,
// then the read-modify-write runs in the execute state. Init writes the count of every managed
// page and the link of each page but page 0 and the reserved range. Modes 5..7 give no result.
// Reset empties the list; the memories are not cleared and init must run before use.
// A finished result holds the block until the output register is free; a new item
// is taken while the previous result still waits in the output register.
`default_nettype none

module page_free_list_allocator_core #(
  parameter int unsigned MAX_PAGES   = pfla_pkg::MAX_PAGES_DEF,
  parameter int unsigned COUNT_WIDTH = pfla_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pfla_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [pfla_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [pfla_pkg::MODE_W-1:0]      mode_i,
  input  wire logic [pfla_pkg::PAGE_W-1:0]      page_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [pfla_pkg::STATUS_W-1:0]    status_o,
  output logic      [pfla_pkg::PAGE_W-1:0]      page_out_o,
  output logic      [pfla_pkg::REFCNT_W-1:0]    ref_count_o,
  output logic                                  was_freed_o
);

  localparam int unsigned AW   = $clog2(MAX_PAGES);
  localparam int unsigned LW   = $clog2(MAX_PAGES + 1);
  localparam int unsigned CMPW = (LW > pfla_pkg::CFG_W) ? LW : pfla_pkg::CFG_W;
  localparam logic [LW-1:0]          NULL_LINK = LW'(MAX_PAGES);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INIT = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [pfla_pkg::CFG_W-1:0]      page_count_q, rsv_begin_q, rsv_end_q;
  logic [LW-1:0]                   head_q, head_d;
  logic [LW-1:0]                   idx_q;
  logic [pfla_pkg::MODE_W-1:0]     mode_q;
  logic [pfla_pkg::PAGE_W-1:0]     page_q;
  logic                            out_valid_q;
  logic [pfla_pkg::STATUS_W-1:0]   status_q;
  logic [pfla_pkg::PAGE_W-1:0]     page_out_q;
  logic [pfla_pkg::REFCNT_W-1:0]   ref_count_q;
  logic                            was_freed_q;

  logic [CMPW-1:0]         managed;
  logic                    in_acc, out_free, fire, init_act, init_rsv, bad_idx;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic                    cnt_we, lnk_we;
  logic [COUNT_WIDTH-1:0]  cnt_wdata, cnt_rdata, cnt_inc, cnt_dec;
  logic [LW-1:0]           lnk_rdata;

  logic                           ex_cnt_we, ex_lnk_we, res_freed;
  logic [COUNT_WIDTH-1:0]         ex_cnt_wdata;
  logic [pfla_pkg::STATUS_W-1:0]  res_status;
  logic [pfla_pkg::PAGE_W-1:0]    res_page;
  logic [pfla_pkg::REFCNT_W-1:0]  res_count;

  assign managed = (CMPW'(page_count_q) > CMPW'(MAX_PAGES)) ? CMPW'(MAX_PAGES)
                                                             : CMPW'(page_count_q);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = (state_q == S_EXEC) && out_free;

  assign init_act = (state_q == S_INIT) && (CMPW'(idx_q) < managed);
  assign init_rsv = (idx_q == '0) ||
                    ((CMPW'(idx_q) >= CMPW'(rsv_begin_q)) && (CMPW'(idx_q) < CMPW'(rsv_end_q)));
  assign bad_idx  = CMPW'(page_q) >= managed;

  assign rd_addr = (mode_i == pfla_pkg::MODE_ALLOC) ? AW'(head_q) : AW'(page_i);
  assign wr_addr = (state_q == S_INIT) ? AW'(idx_q) : AW'(page_q);

  assign cnt_inc = cnt_rdata + COUNT_WIDTH'(1);
  assign cnt_dec = cnt_rdata - COUNT_WIDTH'(1);

  assign cnt_we    = (init_act) || (fire && ex_cnt_we);
  assign cnt_wdata = (state_q == S_INIT) ? (init_rsv ? COUNT_WIDTH'(1) : '0) : ex_cnt_wdata;
  assign lnk_we    = (init_act && !init_rsv) || (fire && ex_lnk_we);

  pfla_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_PAGES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (wr_addr),
    .wdata_i (cnt_wdata),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (cnt_rdata)
  );

  pfla_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_PAGES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (wr_addr),
    .wdata_i (head_q),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (lnk_rdata)
  );

  // read-modify-write of the item in flight
  always_comb begin
    res_status   = pfla_pkg::STATUS_OK;
    res_page     = page_q;
    res_count    = '0;
    res_freed    = 1'b0;
    ex_cnt_we    = 1'b0;
    ex_cnt_wdata = cnt_inc;
    ex_lnk_we    = 1'b0;
    head_d       = head_q;
    case (mode_q)
      pfla_pkg::MODE_INIT: begin
        res_page = (head_q == NULL_LINK) ? '0 : pfla_pkg::PAGE_W'(head_q);
      end
      pfla_pkg::MODE_ALLOC: begin
        if (head_q == NULL_LINK) begin
          res_status = pfla_pkg::STATUS_EMPTY;
          res_page   = '0;
        end else begin
          res_page  = pfla_pkg::PAGE_W'(head_q);
          res_count = pfla_pkg::REFCNT_W'(cnt_rdata);
          head_d    = lnk_rdata;
        end
      end
      pfla_pkg::MODE_FREE: begin
        if (bad_idx) begin
          res_status = pfla_pkg::STATUS_BAD_INDEX;
        end else if (cnt_rdata != '0) begin
          res_status = pfla_pkg::STATUS_BUSY;
          res_count  = pfla_pkg::REFCNT_W'(cnt_rdata);
        end else begin
          ex_lnk_we = 1'b1;
          head_d    = LW'(page_q);
          res_freed = 1'b1;
        end
      end
      pfla_pkg::MODE_INCREF: begin
        if (bad_idx) begin
          res_status = pfla_pkg::STATUS_BAD_INDEX;
        end else if (cnt_rdata == COUNT_MAX) begin
          res_status = pfla_pkg::STATUS_OVERFLOW;
          res_count  = pfla_pkg::REFCNT_W'(cnt_rdata);
        end else begin
          ex_cnt_we = 1'b1;
          res_count = pfla_pkg::REFCNT_W'(cnt_inc);
        end
      end
      pfla_pkg::MODE_DECREF: begin
        if (bad_idx) begin
          res_status = pfla_pkg::STATUS_BAD_INDEX;
        end else if (cnt_rdata == '0) begin
          res_status = pfla_pkg::STATUS_UNDERFLOW;
        end else begin
          ex_cnt_we    = 1'b1;
          ex_cnt_wdata = cnt_dec;
          res_count    = pfla_pkg::REFCNT_W'(cnt_dec);
          if (cnt_dec == '0) begin
            ex_lnk_we = 1'b1;
            head_d    = LW'(page_q);
            res_freed = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            pfla_pkg::MODE_INIT: state_d = S_INIT;
            pfla_pkg::MODE_ALLOC, pfla_pkg::MODE_FREE,
            pfla_pkg::MODE_INCREF, pfla_pkg::MODE_DECREF: state_d = S_EXEC;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        if (!init_act) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= NULL_LINK;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      page_count_q <= pfla_pkg::PAGE_COUNT_RST;
      rsv_begin_q  <= pfla_pkg::RESERVED_BEGIN_RST;
      rsv_end_q    <= pfla_pkg::RESERVED_END_RST;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pfla_pkg::REG_PAGE_COUNT:     page_count_q <= cfg_data_i;
          pfla_pkg::REG_RESERVED_BEGIN: rsv_begin_q  <= cfg_data_i;
          pfla_pkg::REG_RESERVED_END:   rsv_end_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc && mode_i == pfla_pkg::MODE_INIT) begin
        head_q <= NULL_LINK;
        idx_q  <= '0;
      end else if (init_act) begin
        idx_q <= idx_q + LW'(1);
        if (!init_rsv) head_q <= idx_q;
      end else if (fire) begin
        head_q <= head_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_i;
      page_q <= page_i;
    end
    if (fire) begin
      status_q    <= res_status;
      page_out_q  <= res_page;
      ref_count_q <= res_count;
      was_freed_q <= res_freed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign page_out_o  = page_out_q;
  assign ref_count_o = ref_count_q;
  assign was_freed_o = was_freed_q;

endmodule

`default_nettype wire

// File: rtl/pfla_checker.sv
// Port-level checks for the page allocator, bound to the top level.
`default_nettype none

module pfla_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic [pfla_pkg::STATUS_W-1:0]    status_o,
  input wire logic [pfla_pkg::PAGE_W-1:0]      page_out_o,
  input wire logic [pfla_pkg::REFCNT_W-1:0]    ref_count_o,
  input wire logic                             was_freed_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(page_out_o) && $stable(ref_count_o) && $stable(was_freed_o))
    else $error("result changed while stalled");

  a_freed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_freed_o |-> status_o == pfla_pkg::STATUS_OK && ref_count_o == '0)
    else $error("freed page with bad status or nonzero count");

  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == pfla_pkg::STATUS_EMPTY ||
    status_o == pfla_pkg::STATUS_BAD_INDEX || status_o == pfla_pkg::STATUS_UNDERFLOW)
    |-> ref_count_o == '0 && !was_freed_o)
    else $error("error status with nonzero count");

  a_empty_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pfla_pkg::STATUS_EMPTY |-> page_out_o == '0)
    else $error("empty alloc returned a page");

endmodule

bind page_free_list_allocator_core pfla_checker u_pfla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .page_out_o  (page_out_o),
  .ref_count_o (ref_count_o),
  .was_freed_o (was_freed_o)
);

`default_nettype wire
